>>> hw/rtl/tta_pkg.sv
// Package for the thermistor temperature alarm: shared types, probe coefficient
// tables and fixed-point constants. No dependencies.
package tta_pkg;

   localparam int unsigned SumWidth  = 14;
   localparam int unsigned TempWidth = 16;
   localparam logic [15:0] Ln2Q16 = 16'd45426;
   localparam logic [15:0] KelvinOffsetCenti = 16'd27300;

   typedef enum logic [2:0] {
      ALARM_NONE   = 3'b000,
      ALARM_HIGH   = 3'b001,
      ALARM_LOW    = 3'b010,
      ALARM_NOSENS = 3'b011,
      ALARM_UNUSED = 3'b100
   } alarm_code_type;

   typedef enum logic [2:0] {
      CSR_ENABLE = 3'd0,
      CSR_PROBE  = 3'd1,
      CSR_MODE   = 3'd2,
      CSR_HIGH   = 3'd3,
      CSR_LOW    = 3'd4
   } csr_index_type;

   // Start and done handshake between the control sequencer and the math unit.
   typedef struct packed {
      logic        start;
      logic [9:0]  avg;
      logic [1:0]  probe;
   } math_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] temp;
   } math_rsp_type;

   function automatic logic [31:0] coef_a(input logic [1:0] p);
      case (p)
         2'd0:    coef_a = 32'd3676766883;
         2'd1:    coef_a = 32'd3671269325;
         2'd2:    coef_a = 32'd3696558093;
         default: coef_a = 32'd3667312843;
      endcase
   endfunction

   function automatic logic [28:0] coef_b(input logic [1:0] p);
      coef_b = (p == 2'd3) ? 29'd247390116 : 29'd276979074;
   endfunction

   function automatic logic [21:0] coef_c(input logic [1:0] p);
      coef_c = (p == 2'd3) ? 22'd2760808 : 22'd3860319;
   endfunction

   function automatic logic [9:0] probe_rn(input logic [1:0] p);
      case (p)
         2'd0, 2'd1: probe_rn = 10'd47;
         2'd2:       probe_rn = 10'd100;
         default:    probe_rn = 10'd925;
      endcase
   endfunction

endpackage

>>> hw/rtl/tta_log2.sv
// Fixed-point log2 in Q16, one fraction bit per squaring step (16 steps).
// Does not use tta_pkg; uses one 32x32 multiplier.
module tta_log2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [19:0] value,
   output logic        done,
   output logic [20:0] result
);
   logic [31:0] m_ff, m_in;
   logic [15:0] frac_ff, frac_in;
   logic [4:0]  exp_ff, exp_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] sq;
   logic [33:0] sq_sh;
   logic [4:0]  top;

   always_comb begin
      top = 5'd0;
      for (int i = 0; i < 20; i++) begin
         if (value[i]) top = 5'(i);
      end
   end

   assign sq    = 64'(m_ff) * 64'(m_ff);
   assign sq_sh = sq[63:30];

   always_comb begin
      m_in = m_ff; frac_in = frac_ff; exp_in = exp_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         exp_in = top;
         m_in = 32'(value) << (5'd30 - top);
         frac_in = 16'd0; step_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         frac_in = {frac_ff[14:0], sq_sh[31]};
         m_in = sq_sh[31] ? sq_sh[32:1] : sq_sh[31:0];
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd15) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; step_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; step_ff <= step_in;
      end
      m_ff <= m_in; frac_ff <= frac_in; exp_ff <= exp_in;
   end

   assign done   = done_ff;
   assign result = {exp_ff, frac_ff};
endmodule

>>> hw/rtl/tta_divider.sv
// Restoring divider, one quotient bit per cycle, low 16 bits of floor(100*2^40 / D).
// Standalone; no package use.
module tta_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [33:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);
   // Dividend 100*2^40 is 47 bits wide.
   localparam logic [46:0] Dividend = 47'd100 << 40;
   logic [46:0] dvd_ff, dvd_in;
   logic [34:0] rem_ff, rem_in;
   logic [15:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [34:0] trial;
   logic [34:0] diff;

   assign trial = {rem_ff[33:0], dvd_ff[46]};
   assign diff  = trial - 35'(divisor);

   always_comb begin
      dvd_in = dvd_ff; rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         dvd_in = Dividend; rem_in = 35'd0; q_in = 16'd0;
         cnt_in = 6'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[45:0], 1'b0};
         if (!diff[34]) begin
            rem_in = diff; q_in = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = trial; q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd46) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in; rem_ff <= rem_in; q_ff <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

>>> hw/rtl/tta_math.sv
// Temperature math: two log2 passes on a shared serial unit, the polynomial in
// registered steps and a serial divide. Depends on tta_pkg, tta_log2, tta_divider.
module tta_math (
   input  logic                  clock,
   input  logic                  reset,
   input  tta_pkg::math_req_type req,
   output tta_pkg::math_rsp_type rsp
);
   import tta_pkg::*;

   typedef enum logic [10:0] {
      M_IDLE  = 11'b00000000001,
      M_LOAD  = 11'b00000000010,
      M_LNUM  = 11'b00000000100,
      M_LDEN  = 11'b00000001000,
      M_DIFF  = 11'b00000010000,
      M_VM    = 11'b00000100000,
      M_SQ    = 11'b00001000000,
      M_TERMS = 11'b00010000000,
      M_SUM   = 11'b00100000000,
      M_DIV   = 11'b01000000000,
      M_DONE  = 11'b10000000000
   } mstate_type;

   mstate_type  st_ff, st_in;
   logic [9:0]  avg_ff;
   logic [1:0]  probe_ff;
   logic [20:0] lnum_ff, lden_ff;
   logic [20:0] mag_ff;
   logic        neg_ff;
   logic [20:0] vm_ff;
   logic [27:0] vsq_ff;
   logic [34:0] bt_ff, ct_ff;
   logic [33:0] d_ff;
   logic [15:0] temp_ff;
   logic        lstart, dstart, ldone, ddone;
   logic [19:0] lval;
   logic [20:0] lres;
   logic [15:0] quo;
   logic [36:0] mag_prod;
   logic [43:0] vsq_prod;
   logic [50:0] b_prod;
   logic [49:0] c_prod;
   logic [36:0] dsum;

   // The numerator pass starts from the load state, the denominator pass
   // right after the numerator finishes.
   assign lval = (st_ff == M_LOAD)
      ? 20'(18'd200 * (18'd1024 - 18'(avg_ff)))
      : 20'(avg_ff) * 20'(probe_rn(probe_ff));

   tta_log2 u_log2 (.clock, .reset, .start(lstart), .value(lval),
                    .done(ldone), .result(lres));
   tta_divider u_div (.clock, .reset, .start(dstart), .divisor(d_ff),
                      .done(ddone), .quotient(quo));

   assign mag_prod = 37'(mag_ff) * 37'(Ln2Q16) + 37'd32768;
   assign vsq_prod = 44'(vm_ff) * 44'(vm_ff);
   assign b_prod   = 51'(coef_b(probe_ff)) * 51'(vm_ff);
   assign c_prod   = 50'(coef_c(probe_ff)) * 50'(vsq_ff);
   assign dsum     = neg_ff
      ? 37'(coef_a(probe_ff)) - 37'(bt_ff) + 37'(ct_ff)
      : 37'(coef_a(probe_ff)) + 37'(bt_ff) + 37'(ct_ff);

   always_comb begin
      st_in = st_ff; lstart = 1'b0; dstart = 1'b0;
      unique case (st_ff)
         M_IDLE:  if (req.start) begin
            st_in = (req.avg == 10'd0) ? M_DONE : M_LOAD;
         end
         M_LOAD:  begin st_in = M_LNUM; lstart = 1'b1; end
         M_LNUM:  if (ldone) begin st_in = M_LDEN; lstart = 1'b1; end
         M_LDEN:  if (ldone) st_in = M_DIFF;
         M_DIFF:  st_in = M_VM;
         M_VM:    st_in = M_SQ;
         M_SQ:    st_in = M_TERMS;
         M_TERMS: st_in = M_SUM;
         M_SUM:   begin st_in = M_DIV; dstart = 1'b1; end
         M_DIV:   if (ddone) st_in = M_DONE;
         M_DONE:  st_in = M_IDLE;
         default: st_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= M_IDLE;
      else       st_ff <= st_in;
      if (st_ff == M_IDLE && req.start) begin
         avg_ff <= req.avg; probe_ff <= req.probe;
         temp_ff <= 16'd0 - KelvinOffsetCenti;
      end
      if (st_ff == M_LNUM && ldone) lnum_ff <= lres;
      if (st_ff == M_LDEN && ldone) lden_ff <= lres;
      if (st_ff == M_DIFF) begin
         neg_ff <= lnum_ff < lden_ff;
         mag_ff <= (lnum_ff >= lden_ff) ? lnum_ff - lden_ff : lden_ff - lnum_ff;
      end
      if (st_ff == M_VM)    vm_ff <= mag_prod[36:16];
      if (st_ff == M_SQ)    vsq_ff <= vsq_prod[43:16];
      if (st_ff == M_TERMS) begin
         bt_ff <= b_prod[50:16]; ct_ff <= 35'(c_prod[49:16]);
      end
      if (st_ff == M_SUM) d_ff <= (dsum[36] || dsum == 37'd0) ? 34'd1 : dsum[33:0];
      if (st_ff == M_DIV && ddone) temp_ff <= quo - KelvinOffsetCenti;
   end

   assign rsp.done = (st_ff == M_DONE);
   assign rsp.temp = temp_ff;

   a_div_after_sum: assert property (@(posedge clock) disable iff (reset)
      st_ff == M_SUM |=> st_ff == M_DIV) else $error("divider not started");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done) else $error("done held");
   a_idle_start: assert property (@(posedge clock) disable iff (reset)
      (st_ff == M_IDLE && req.start) |=> st_ff != M_IDLE) else $error("start lost");
endmodule

>>> hw/rtl/thermistor_temperature_alarm_top.sv
// Top level of the thermistor temperature alarm: sample accumulation, alarm
// classification and result register. Depends on tta_pkg and tta_math.
//
// Usage: req_valid/req_ready carry one 10-bit converter word per accepted
// handshake. While sensor_enabled is 1, every SAMPLES_PER_RESULT words form a
// group; the last word of a group starts the temperature computation and the
// block produces one rsp word (temperature_centi, sensor_status, alarm_state).
// Words accepted while disabled are dropped with no result.
// Flow: words inside a group are accepted back to back while no computation
// runs. The result of the closing word is offered after a load step, two
// 16-step serial log2 passes, five registered multiply and sum steps and a
// 47-step restoring divide; a zero average skips straight from the start to
// the result.
// req_ready stays low during that computation.
// The result sits in an output register; while the receiver stalls, the
// block still takes words of the next group and only holds the next closing
// word until the register frees up.
// Reset: synchronous, active high; clears the sum, count, alarm activity and
// restores all configuration registers to their defaults.
// Configuration is written through csr_write/csr_index/csr_data, no wait.
module thermistor_temperature_alarm_top #(
   parameter int unsigned SAMPLES_PER_RESULT = 10,
   parameter int unsigned HYSTERESIS = 200,
   parameter int unsigned UNDEFINED_TEMP = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_adc_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_temperature_centi,
   output logic        rsp_sensor_status,
   output logic [1:0]  rsp_alarm_state,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import tta_pkg::*;

   localparam logic [3:0] LastCount = 4'(SAMPLES_PER_RESULT - 1);
   localparam logic [20:0] AvgRecip =
      21'((2**20 + SAMPLES_PER_RESULT - 1) / SAMPLES_PER_RESULT);

   logic        enabled_ff;
   logic [1:0]  probe_ff, mode_ff;
   logic [15:0] high_ff, low_ff;
   logic [13:0] sum_ff, sum_in;
   logic [3:0]  count_ff;
   logic        active_ff;
   logic        busy_ff;
   logic        nosens_ff;
   logic        out_valid_ff;
   logic [15:0] out_temp_ff;
   logic        out_status_ff;
   logic [1:0]  out_alarm_ff;
   logic        accept, closing;
   logic [34:0] avg_prod;
   math_req_type mreq;
   math_rsp_type mrsp;
   logic [15:0] temp;
   logic        high_sel, low_sel, is_high, is_low;
   alarm_code_type alarm;

   assign closing   = enabled_ff && count_ff == LastCount;
   assign req_ready = !busy_ff && !(closing && out_valid_ff);
   assign accept    = req_valid && req_ready;
   assign sum_in    = sum_ff + 14'(req_adc_sample);
   // Divide by the group size as a reciprocal multiply; exact for 14-bit sums.
   assign avg_prod  = 35'(sum_in) * 35'(AvgRecip);

   assign mreq.start = accept && closing;
   assign mreq.avg   = avg_prod[29:20];
   assign mreq.probe = probe_ff;

   tta_math u_math (.clock, .reset, .req(mreq), .rsp(mrsp));

   assign temp     = nosens_ff ? 16'(UNDEFINED_TEMP) : mrsp.temp;
   assign high_sel = mode_ff[0];
   assign low_sel  = mode_ff[1];
   always_comb begin
      if (!active_ff) begin
         is_high = high_sel && temp > high_ff;
         is_low  = low_sel && temp < low_ff;
      end else begin
         is_high = high_sel && $signed({2'b0, temp}) >
                   $signed({2'b0, high_ff}) - $signed(18'(HYSTERESIS));
         is_low  = low_sel && 18'(temp) < 18'(low_ff) + 18'(HYSTERESIS);
      end
      if (is_high)        alarm = ALARM_HIGH;
      else if (is_low)    alarm = ALARM_LOW;
      else if (nosens_ff) alarm = ALARM_NOSENS;
      else                alarm = ALARM_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0; probe_ff <= 2'd3; mode_ff <= 2'd0;
         high_ff <= 16'hFFFF; low_ff <= 16'd0;
         sum_ff <= 14'd0; count_ff <= 4'd0; active_ff <= 1'b0;
         busy_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         if (accept && enabled_ff) begin
            if (closing) begin
               sum_ff <= 14'd0; count_ff <= 4'd0; busy_ff <= 1'b1;
            end else begin
               sum_ff <= sum_in; count_ff <= count_ff + 4'd1;
            end
         end
         if (mrsp.done) begin
            busy_ff <= 1'b0; out_valid_ff <= 1'b1;
            active_ff <= (alarm == ALARM_HIGH) || (alarm == ALARM_LOW);
         end else if (rsp_valid && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_ENABLE: begin
                  enabled_ff <= csr_data[0];
                  if (!csr_data[0]) begin
                     active_ff <= 1'b0; sum_ff <= 14'd0; count_ff <= 4'd0;
                  end
               end
               CSR_PROBE: probe_ff <= csr_data[1:0];
               CSR_MODE:  mode_ff <= csr_data[1:0];
               CSR_HIGH:  high_ff <= csr_data;
               CSR_LOW:   low_ff <= csr_data;
               default:   ;
            endcase
         end
      end
      if (mreq.start) nosens_ff <= (sum_in == 14'd0);
      if (mrsp.done) begin
         out_temp_ff <= temp; out_status_ff <= nosens_ff;
         out_alarm_ff <= alarm[1:0];
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_temperature_centi = out_temp_ff;
   assign rsp_sensor_status     = out_status_ff;
   assign rsp_alarm_state       = out_alarm_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> !(out_valid_ff && !rsp_ready)) else $error("result overwritten");
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready) else $error("input taken while busy");
   a_status_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sensor_status && rsp_alarm_state == 2'd0) |-> 1'b0)
      else $error("no-sensor without alarm code");
endmodule

>>> tb/thermistor_temperature_alarm_checker.sv
// Checker for the thermistor temperature alarm: watches the register port and both
// word channels, predicts each result and compares it field by field.
// Depends on tta_pkg for the register indexes and alarm codes.
`timescale 1ns / 100ps

module thermistor_temperature_alarm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [9:0]  req_adc_sample,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_temperature_centi,
   input  logic        rsp_sensor_status,
   input  logic [1:0]  rsp_alarm_state,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          result_count
);
   import tta_pkg::*;

   localparam int unsigned GroupSize = 10;
   localparam int unsigned Hyst = 200;
   localparam logic [15:0] NoSensorTemp = 16'hFFFF;

   typedef struct {
      logic [15:0]    temp;
      logic           status;
      alarm_code_type alarm;
   } reading_type;

   // Q40 Steinhart-Hart coefficients and divider resistances per probe.
   localparam longint CoefA[4] = '{64'd3676766883, 64'd3671269325, 64'd3696558093,
                                   64'd3667312843};
   localparam longint CoefB[4] = '{64'd276979074, 64'd276979074, 64'd276979074,
                                   64'd247390116};
   localparam longint CoefC[4] = '{64'd3860319, 64'd3860319, 64'd3860319, 64'd2760808};
   localparam int unsigned Rn[4] = '{47, 47, 100, 925};

   reading_type readings_due[$];

   logic        enabled;
   logic [1:0]  probe;
   logic [1:0]  mode;
   logic [15:0] high_border;
   logic [15:0] low_border;
   logic [13:0] group_sum;
   logic [3:0]  group_count;
   logic        in_alarm;

   // Q16 log2 by repeated squaring of a Q30 mantissa.
   function automatic int unsigned log2_fixed(input int unsigned n);
      int unsigned e;
      int unsigned frac;
      longint unsigned m;
      e = 0;
      frac = 0;
      if (n == 0) return 0;
      while (e < 31 && (n >> (e + 1)) != 0) e++;
      if (e > 30) e = 30;
      m = longint'(n) << (30 - e);
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac |= 1 << i;
         end
      end
      return (e << 16) | frac;
   endfunction

   function automatic logic [15:0] centi_degrees(input int unsigned avg, input logic [1:0] p);
      int unsigned lnum;
      int unsigned lden;
      longint unsigned mag;
      longint unsigned vm;
      longint unsigned k;
      longint d;
      if (avg == 0) return 16'(0 - 27300);
      lnum = log2_fixed(200 * (1024 - avg));
      lden = log2_fixed(avg * Rn[p]);
      mag = (lnum >= lden) ? lnum - lden : lden - lnum;
      vm = (mag * 45426 + 32768) >> 16;
      d = CoefA[p];
      if (lnum >= lden) d += longint'((CoefB[p] * vm) >> 16);
      else d -= longint'((CoefB[p] * vm) >> 16);
      d += longint'((CoefC[p] * ((vm * vm) >> 16)) >> 16);
      if (d < 1) d = 1;
      k = (64'd100 << 40) / longint'(d);
      return 16'(k) - 16'd27300;
   endfunction

   task automatic take_sample(input logic [9:0] s);
      reading_type r;
      bit want_high;
      bit want_low;
      bit is_high;
      bit is_low;
      if (!enabled) return;
      group_sum = group_sum + 14'(s);
      if (int'(group_count) + 1 < GroupSize) begin
         group_count = group_count + 1;
         return;
      end
      if (group_sum == 0) begin
         r.temp = NoSensorTemp;
         r.status = 1'b1;
      end else begin
         r.temp = centi_degrees(group_sum / GroupSize, probe);
         r.status = 1'b0;
      end
      group_sum = '0;
      group_count = '0;
      want_high = (mode == 2'd1) || (mode == 2'd3);
      want_low = (mode == 2'd2) || (mode == 2'd3);
      if (!in_alarm) begin
         is_high = want_high && r.temp > high_border;
         is_low = want_low && r.temp < low_border;
      end else begin
         is_high = want_high && int'(r.temp) > int'(high_border) - int'(Hyst);
         is_low = want_low && int'(r.temp) < int'(low_border) + int'(Hyst);
      end
      if (is_high) r.alarm = ALARM_HIGH;
      else if (is_low) r.alarm = ALARM_LOW;
      else if (r.status) r.alarm = ALARM_NOSENS;
      else r.alarm = ALARM_NONE;
      in_alarm = is_high || is_low;
      readings_due.push_back(r);
   endtask

   always @(posedge clock) begin
      reading_type r;
      if (reset) begin
         enabled = 1'b0;
         probe = 2'd3;
         mode = 2'd0;
         high_border = 16'hFFFF;
         low_border = 16'h0000;
         group_sum = '0;
         group_count = '0;
         in_alarm = 1'b0;
         readings_due.delete();
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_ENABLE: begin
                  enabled = csr_data[0];
                  if (!enabled) begin
                     in_alarm = 1'b0;
                     group_sum = '0;
                     group_count = '0;
                  end
               end
               CSR_PROBE: probe = csr_data[1:0];
               CSR_MODE: mode = csr_data[1:0];
               CSR_HIGH: high_border = csr_data;
               CSR_LOW: low_border = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) take_sample(req_adc_sample);
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (readings_due.size() == 0) begin
               $error("result word with no reading due: temp %0d", rsp_temperature_centi);
               fail_count++;
            end else begin
               r = readings_due.pop_front();
               if (rsp_temperature_centi !== r.temp) begin
                  $error("temperature_centi expected %0d actual %0d", r.temp,
                         rsp_temperature_centi);
                  fail_count++;
               end
               if (rsp_sensor_status !== r.status) begin
                  $error("sensor_status expected %0d actual %0d", r.status, rsp_sensor_status);
                  fail_count++;
               end
               if (rsp_alarm_state !== r.alarm[1:0]) begin
                  $error("alarm_state expected %0d actual %0d", r.alarm[1:0], rsp_alarm_state);
                  fail_count++;
               end
            end
         end
      end
      pending = readings_due.size();
   end

   initial begin
      fail_count = 0;
      result_count = 0;
      pending = 0;
   end

endmodule

>>> tb/thermistor_temperature_alarm_top_test.sv
// Testbench top for the thermistor temperature alarm: clock, reset, stimulus and
// verdict. Depends on tta_pkg, the block and thermistor_temperature_alarm_checker.
`timescale 1ns / 100ps

module thermistor_temperature_alarm_top_test;
   import tta_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [9:0]  req_adc_sample;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_temperature_centi;
   logic        rsp_sensor_status;
   logic [1:0]  rsp_alarm_state;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   int          fail_count;
   int          pending;
   int          result_count;
   int          send_gap_pct;
   int          stall_pct;
   int          words_sent;

   thermistor_temperature_alarm_top dut (.*);

   thermistor_temperature_alarm_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (stall_pct == 0) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_word(input logic [9:0] s);
      // Each cycle the sender idles with the given chance before offering a word.
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= s;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Let the block drain and finish any computation before touching registers.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_config(input logic en, input logic [1:0] p, input logic [1:0] m,
                             input logic [15:0] hi, input logic [15:0] lo);
      csr_write <= 1'b1;
      csr_index <= CSR_ENABLE;
      csr_data <= 16'(en);
      @(posedge clock);
      csr_index <= CSR_PROBE;
      csr_data <= 16'(p);
      @(posedge clock);
      csr_index <= CSR_MODE;
      csr_data <= 16'(m);
      @(posedge clock);
      csr_index <= CSR_HIGH;
      csr_data <= hi;
      @(posedge clock);
      csr_index <= CSR_LOW;
      csr_data <= lo;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send_group(input logic [9:0] first, input logic [9:0] rest);
      send_word(first);
      repeat (9) send_word(rest);
   endtask

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(12000));
      endcase
   endfunction

   initial begin
      int base;
      int style;
      int n;
      int v;
      reset = 1'b1;
      req_valid = 1'b0;
      req_adc_sample = '0;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_gap_pct = 13;
      stall_pct = 83;
      words_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Words taken while disabled are dropped.
      send_word(10'h3FF);
      send_word(10'h155);
      settle();
      set_config(1'b1, 2'd3, 2'd3, 16'hFFFF, 16'h0000);
      send_group(10'd0, 10'd0);       // no sensor
      send_group(10'd5, 10'd0);       // nonzero sum, average of zero
      send_group(10'h3FF, 10'h3FF);   // full scale
      settle();
      set_config(1'b1, 2'd0, 2'd1, 16'd0, 16'd0);
      send_group(10'd512, 10'd512);
      settle();
      set_config(1'b1, 2'd2, 2'd2, 16'd0, 16'hFFFF);
      send_group(10'd300, 10'd700);

      for (int ph = 0; ph < 3; ph++) begin
         send_gap_pct = (ph == 0) ? 13 : (ph == 1) ? 83 : 0;
         stall_pct = (ph == 0) ? 83 : (ph == 1) ? 13 : 0;
         for (int s = 0; s < 10; s++) begin
            settle();
            // Sometimes disable first so a partial group is thrown away.
            if ($urandom_range(3) == 0) set_config(1'b0, 2'd3, 2'd0, 16'hFFFF, 16'h0);
            set_config(1'b1, 2'($urandom), 2'($urandom), pick_limit(), pick_limit());
            base = $urandom_range(1023);
            style = $urandom_range(5);
            n = $urandom_range(35, 55);
            for (int i = 0; i < n; i++) begin
               case (style)
                  0: v = $urandom_range(1023);
                  1: v = ($urandom_range(9) == 0) ? $urandom_range(1023) : 0;
                  2: v = ($urandom_range(3) == 0) ? $urandom_range(15) : 0;
                  default: begin
                     v = base + $urandom_range(30) - 15;
                     if ($urandom_range(20) == 0) base = $urandom_range(1023);
                  end
               endcase
               if (v < 0) v = 0;
               if (v > 1023) v = 1023;
               send_word(10'(v));
            end
         end
      end
      settle();
      $display("Sent %0d words over all probes and alarm modes; %0d results checked.",
               words_sent, result_count);
      if (fail_count == 0) begin
         $display("thermistor_temperature_alarm_top regression: pass");
      end else begin
         $display("thermistor_temperature_alarm_top regression: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("thermistor_temperature_alarm_top regression: fail");
      $finish;
   end

endmodule
